FILE: rtl/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg
// Shared widths and types for the sliding window max spread block.
// ----------------------------------------------------------------------------
package swms_pkg;

    // sample and spread width
    localparam int SAMPLE_W = 31;
    // window length register width
    localparam int CFG_W    = 7;
    // stream data width, sample padded to whole bytes
    localparam int TDATA_W  = 32;
    // window length after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // running extremes held by one cell of the chain
    typedef struct packed {
        sample_t hi;
        sample_t lo;
    } extreme_t;

endpackage

FILE: rtl/swms_cell.sv
// ----------------------------------------------------------------------------
// swms_cell
// One cell of the extremes chain: max and min of the newest k+1 samples.
// ----------------------------------------------------------------------------
module swms_cell (
    input  logic               aclk,
    input  logic               shift_en,
    input  swms_pkg::sample_t  sample,
    input  swms_pkg::extreme_t prev_cell,
    output swms_pkg::extreme_t extremes
);
    import swms_pkg::*;

    extreme_t cell_reg;
    extreme_t cell_next;

    // fold the new sample into the neighbor's registered extremes
    always_comb begin
        cell_next.hi = (sample > prev_cell.hi) ? sample : prev_cell.hi;
        cell_next.lo = (sample < prev_cell.lo) ? sample : prev_cell.lo;
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            cell_reg <= cell_next;
        end
    end

    assign extremes = cell_reg;

endmodule

FILE: rtl/sliding_window_max_spread_top.sv
// ----------------------------------------------------------------------------
// sliding_window_max_spread_top
// Largest (max - min) over all windows of a sample sequence.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one sample per transaction in s_tdata[30:0]; s_tlast
//   marks the final sample of a sequence. The m_ channel carries one result
//   per sequence, the largest window spread, in m_tdata[30:0] (0 when the
//   sequence was shorter than the window).
//   cfg_we / cfg_wdata write the window length (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle.
// Throughput and result path:
//   samples without tlast are taken one per cycle. The result appears on
//   m_tvalid after the edge that accepted the tlast sample: the chain
//   shifts at that edge, the window cell's spread is registered in stage 1
//   and then folded into the running best and the result register. s_tready
//   stays low from a tlast transaction until its result has been taken, so
//   a sequence end is always followed by a gap in which no sample is taken.
// Reset:
//   aresetn (synchronous, active low) clears the fill count, best spread and
//   m_tvalid, and sets the window length to 1. Cells and m_tdata are not cleared.
// Stall:
//   while m_tready is low the result holds and s_tready stays low.
// ----------------------------------------------------------------------------
module sliding_window_max_spread_top #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: window_length
    input  logic                        cfg_we,
    input  logic [swms_pkg::CFG_W-1:0]  cfg_wdata,
    // sample stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swms_pkg::TDATA_W-1:0] s_tdata,  // [30:0] sample, [31] unused
    input  logic                        s_tlast,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swms_pkg::TDATA_W-1:0] m_tdata   // [30:0] max_spread, [31] zero
);
    import swms_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    logic [CFG_W-1:0] win_len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_inc;
    logic [LEN_W-1:0] eff_len;
    logic [IDX_W-1:0] sel_idx;
    logic             s_fire;
    sample_t          in_sample;

    // stage 0: flags riding with the chain update
    logic             v0_reg;
    logic             l0_reg;
    logic             e0_reg;
    // stage 1: spread of the selected window
    logic             v1_reg;
    logic             l1_reg;
    logic             e1_reg;
    sample_t          diff_reg;

    sample_t          best_reg;
    sample_t          best_next;
    logic             m_tvalid_reg;
    sample_t          m_data_reg;

    extreme_t         chain [WINDOW_MAX];
    extreme_t         sel_cell;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign s_fire    = s_tvalid && s_tready;

    // block new samples while a sequence end is in flight or unread
    assign s_tready = !m_tvalid_reg && !(v0_reg && l0_reg) && !(v1_reg && l1_reg);

    // effective window length and the cell that holds its extremes
    always_comb begin
        if (win_len_reg == '0) begin
            eff_len = LEN_ONE;
        end else if (32'(win_len_reg) > 32'(WINDOW_MAX)) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = LEN_W'(win_len_reg);
        end
        sel_idx = IDX_W'(eff_len - LEN_ONE);
    end

    // saturating sample count of this sequence
    assign fill_inc = (fill_reg == LEN_MAX) ? fill_reg : fill_reg + LEN_ONE;

    // chain of extreme cells, cell k covers the newest k+1 samples
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            extreme_t prev_cell;
            if (gi == 0) begin : g_head
                assign prev_cell = '{hi: in_sample, lo: in_sample};
            end else begin : g_link
                assign prev_cell = chain[gi-1];
            end
            swms_cell u_cell (
                .aclk      (aclk),
                .shift_en  (s_fire),
                .sample    (in_sample),
                .prev_cell (prev_cell),
                .extremes  (chain[gi])
            );
        end
    endgenerate

    assign sel_cell = chain[sel_idx];

    // running best including the spread now leaving stage 1
    assign best_next = (e1_reg && (diff_reg > best_reg)) ? diff_reg : best_reg;

    // config register, fill count and stage flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= CFG_RESET;
            fill_reg    <= '0;
            v0_reg      <= 1'b0;
            l0_reg      <= 1'b0;
            e0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            l1_reg      <= 1'b0;
            e1_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                win_len_reg <= cfg_wdata;
            end
            if (s_fire) begin
                fill_reg <= s_tlast ? '0 : fill_inc;
            end
            v0_reg <= s_fire;
            l0_reg <= s_fire && s_tlast;
            e0_reg <= s_fire && (fill_inc >= eff_len);
            v1_reg <= v0_reg;
            l1_reg <= l0_reg;
            e1_reg <= e0_reg;
        end
    end

    // window spread of the selected cell
    always_ff @(posedge aclk) begin
        diff_reg <= sel_cell.hi - sel_cell.lo;
    end

    // best spread and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (v1_reg) begin
                best_reg <= l1_reg ? '0 : best_next;
            end
            if (v1_reg && l1_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && l1_reg) begin
            m_data_reg <= best_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-SAMPLE_W){1'b0}}, m_data_reg};

endmodule
